/* rtl/ttfn_pkg.sv */
package ttfn_pkg;

    localparam int MAT_ENTRIES = 12;
    localparam int VTX_COORDS  = 9;
    localparam int NORM_SHIFT  = 14;

    typedef logic signed [31:0] coord_t;
    typedef logic signed [15:0] norm_t;

    // one queued word: matrix load or triangle
    typedef struct packed {
        logic                  is_load;
        logic [3:0]            idx;
        logic [31:0]           value;
        logic [8:0][31:0]      vtx;
    } item_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_XMUL,
        ST_XACC,
        ST_XFIN,
        ST_EDGE,
        ST_CMUL,
        ST_CACC,
        ST_NCHK,
        ST_NSHIFT,
        ST_SQMUL,
        ST_SQACC,
        ST_ROOT,
        ST_DINIT,
        ST_DSTEP,
        ST_EMIT
    } seq_state_t;

endpackage

/* rtl/ttfn_front.sv */
module ttfn_front import ttfn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       in_item,
    output queue_head_t head,
    input  logic        head_pop
);

    item_t      queue_mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       drop;
    logic       push;
    logic       pop;

    // loads to entries past the matrix are swallowed here
    always_comb
    begin
        drop = in_item.is_load && (in_item.idx inside {[4'd12:4'd15]});
    end

    assign item_stall = (count_reg == 2'd2);
    assign push       = item_valid && !item_stall && !drop;
    assign pop        = head_pop && (count_reg != 2'd0);

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.item  = queue_mem_reg[rd_ptr_reg];

endmodule

/* rtl/ttfn_back.sv */
module ttfn_back import ttfn_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  queue_head_t head,
    output logic        head_pop,
    output logic        result_valid,
    input  logic        result_stall,
    output coord_t      pos_x,
    output coord_t      pos_y,
    output coord_t      pos_z,
    output norm_t       norm_x,
    output norm_t       norm_y,
    output norm_t       norm_z,
    output logic        degenerate,
    output logic        last_vertex
);

    localparam logic signed [65:0] HALF   = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
    localparam logic signed [65:0] SAT_LO = -66'sd2147483648;
    localparam coord_t             MAT_ONE = 32'sd1 <<< FRAC_BITS;
    localparam logic [4:0]         ROOT_LAST = 5'd31;
    localparam logic [4:0]         DIV_LAST  = 5'd15;

    seq_state_t        state_reg;
    seq_state_t        state_next;
    coord_t            mat_reg [MAT_ENTRIES];
    logic [1:0]        k_reg;
    logic [1:0]        r_reg;
    logic [1:0]        c_reg;
    logic [2:0]        j_reg;
    logic [4:0]        cnt_reg;
    logic              out_valid_reg;

    coord_t            vtx_reg [VTX_COORDS];
    coord_t            pos_reg [VTX_COORDS];
    logic signed [63:0] prod_reg;
    logic signed [65:0] acc_reg;
    coord_t            e1_reg [3];
    coord_t            e2_reg [3];
    logic [61:0]       mag_reg [3];
    logic [2:0]        neg_reg;
    logic [63:0]       rx_reg;
    logic [63:0]       rres_reg;
    logic [63:0]       rbit_reg;
    logic [32:0]       len_reg;
    logic [32:0]       rem_reg;
    logic [15:0]       qsh_reg;
    norm_t             norm_reg [3];
    logic              degen_reg;
    coord_t            opos_x_reg;
    coord_t            opos_y_reg;
    coord_t            opos_z_reg;
    norm_t             onorm_x_reg;
    norm_t             onorm_y_reg;
    norm_t             onorm_z_reg;
    logic              odegen_reg;
    logic              olast_reg;

    logic [3:0]        mat_idx;
    logic [3:0]        vidx;
    coord_t            mat_rd;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] mul_p;
    logic signed [65:0] acc_add;
    logic signed [65:0] acc_sub;
    logic signed [65:0] xf_shift;
    logic signed [65:0] xf_total;
    coord_t            xf_sat;
    logic [2:0][31:0]  fit1;
    logic [2:0][31:0]  fit2;
    logic [1:0]        cx_ia;
    logic [1:0]        cx_ib;
    logic [61:0]       mag_or;
    logic [63:0]       root_try;
    logic              root_ge;
    logic [63:0]       rx_step;
    logic [63:0]       rres_step;
    logic [45:0]       div_num;
    logic [33:0]       rem2;
    logic              div_ge;
    logic [15:0]       quot;
    logic              load_out;
    logic [1:0]        cx_comp;

    // bring a triple of edge components below 2^30, shared shift
    function automatic logic [2:0][31:0] fit_edge(input logic [2:0][32:0] d);
        logic [2:0][32:0] m;
        logic [32:0]      o;
        logic [1:0]       s;
        logic [32:0]      a;
        logic [2:0][31:0] res;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = d[i][32] ? (~d[i] + 33'd1) : d[i];
        end
        o = m[0] | m[1] | m[2];
        s = o[32] ? 2'd3 : (o[31] ? 2'd2 : (o[30] ? 2'd1 : 2'd0));
        for (int i = 0; i < 3; i++)
        begin
            a      = m[i] >> s;
            res[i] = d[i][32] ? 32'(~a + 33'd1) : a[31:0];
        end
        return res;
    endfunction

    // cross operand pairs: even j is the plus term, odd j the minus term
    function automatic logic [3:0] cross_sel(input logic [2:0] j);
        logic [3:0] sel;
        case (j)
            3'd0:    sel = {2'd1, 2'd2};
            3'd1:    sel = {2'd2, 2'd1};
            3'd2:    sel = {2'd2, 2'd0};
            3'd3:    sel = {2'd0, 2'd2};
            3'd4:    sel = {2'd0, 2'd1};
            3'd5:    sel = {2'd1, 2'd0};
            default: sel = 4'd0;
        endcase
        return sel;
    endfunction

    function automatic logic [32:0] sx33(input coord_t v);
        return {v[31], v};
    endfunction

    // matrix read: one address, column 3 during the finish step
    assign mat_idx = (state_reg == ST_XFIN) ? {r_reg, 2'd3} : {r_reg, c_reg};
    assign mat_rd  = mat_reg[mat_idx];
    assign vidx    = 4'({k_reg, 1'b0}) + 4'(k_reg) + 4'(c_reg);
    assign {cx_ia, cx_ib} = cross_sel(j_reg);
    assign cx_comp = j_reg[2:1];

    always_comb
    begin
        case (state_reg)
            ST_XMUL:
            begin
                mul_a = mat_rd;
                mul_b = vtx_reg[vidx];
            end
            ST_CMUL:
            begin
                mul_a = e1_reg[cx_ia];
                mul_b = e2_reg[cx_ib];
            end
            ST_SQMUL:
            begin
                mul_a = $signed({1'b0, mag_reg[c_reg][30:0]});
                mul_b = $signed({1'b0, mag_reg[c_reg][30:0]});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign acc_add = acc_reg + 66'(prod_reg);
    assign acc_sub = acc_reg - 66'(prod_reg);

    // round half up, add translation, saturate
    always_comb
    begin
        xf_shift = (acc_reg + HALF) >>> FRAC_BITS;
        xf_total = xf_shift + 66'(mat_rd);
        if (xf_total > SAT_HI)
        begin
            xf_sat = 32'sh7FFFFFFF;
        end
        else if (xf_total < SAT_LO)
        begin
            xf_sat = 32'sh80000000;
        end
        else
        begin
            xf_sat = xf_total[31:0];
        end
    end

    always_comb
    begin
        logic [2:0][32:0] d1;
        logic [2:0][32:0] d2;
        for (int i = 0; i < 3; i++)
        begin
            d1[i] = sx33(pos_reg[6 + i]) - sx33(pos_reg[3 + i]);
            d2[i] = sx33(pos_reg[i]) - sx33(pos_reg[3 + i]);
        end
        fit1 = fit_edge(d1);
        fit2 = fit_edge(d2);
    end

    assign mag_or = mag_reg[0] | mag_reg[1] | mag_reg[2];

    // one bit of the integer square root a cycle
    always_comb
    begin
        root_try  = rres_reg + rbit_reg;
        root_ge   = (rx_reg >= root_try);
        rx_step   = root_ge ? (rx_reg - root_try) : rx_reg;
        rres_step = root_ge ? ((rres_reg >> 1) + rbit_reg) : (rres_reg >> 1);
    end

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        div_num = 46'({mag_reg[c_reg][30:0], 14'd0}) + 46'(len_reg >> 1);
        rem2    = {rem_reg, qsh_reg[15]};
        div_ge  = (rem2 >= {1'b0, len_reg});
        quot    = {qsh_reg[14:0], div_ge};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid && !head.item.is_load)
                begin
                    state_next = ST_XMUL;
                end
            end
            ST_XMUL:   state_next = ST_XACC;
            ST_XACC:   state_next = (c_reg == 2'd2) ? ST_XFIN : ST_XMUL;
            ST_XFIN:
            begin
                state_next = (r_reg == 2'd2 && k_reg == 2'd2) ? ST_EDGE : ST_XMUL;
            end
            ST_EDGE:   state_next = ST_CMUL;
            ST_CMUL:   state_next = ST_CACC;
            ST_CACC:   state_next = (j_reg == 3'd5) ? ST_NCHK : ST_CMUL;
            ST_NCHK:   state_next = (mag_or == '0) ? ST_EMIT : ST_NSHIFT;
            ST_NSHIFT:
            begin
                if (mag_or[61:31] == '0 && mag_or[30])
                begin
                    state_next = ST_SQMUL;
                end
            end
            ST_SQMUL:  state_next = ST_SQACC;
            ST_SQACC:  state_next = (c_reg == 2'd2) ? ST_ROOT : ST_SQMUL;
            ST_ROOT:   state_next = (cnt_reg == ROOT_LAST) ? ST_DINIT : ST_ROOT;
            ST_DINIT:  state_next = ST_DSTEP;
            ST_DSTEP:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = (c_reg == 2'd2) ? ST_EMIT : ST_DINIT;
                end
            end
            ST_EMIT:
            begin
                if (load_out && k_reg == 2'd2)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // decoded controls
    always_comb
    begin
        head_pop = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE: head_pop = head.valid;
            ST_EMIT: load_out = !out_valid_reg || !result_stall;
            default:
            begin
                head_pop = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= 2'd0;
            r_reg         <= 2'd0;
            c_reg         <= 2'd0;
            j_reg         <= 3'd0;
            cnt_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAT_ENTRIES; i++)
            begin
                mat_reg[i] <= '0;
            end
            mat_reg[0]  <= MAT_ONE;
            mat_reg[5]  <= MAT_ONE;
            mat_reg[10] <= MAT_ONE;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= load_out || (out_valid_reg && result_stall);
            case (state_reg)
                ST_IDLE:
                begin
                    k_reg <= 2'd0;
                    r_reg <= 2'd0;
                    c_reg <= 2'd0;
                    if (head.valid && head.item.is_load)
                    begin
                        mat_reg[head.item.idx] <= head.item.value;
                    end
                end
                ST_XACC:
                begin
                    if (c_reg != 2'd2)
                    begin
                        c_reg <= c_reg + 2'd1;
                    end
                end
                ST_XFIN:
                begin
                    c_reg <= 2'd0;
                    if (r_reg == 2'd2)
                    begin
                        r_reg <= 2'd0;
                        k_reg <= k_reg + 2'd1;
                    end
                    else
                    begin
                        r_reg <= r_reg + 2'd1;
                    end
                end
                ST_EDGE:
                begin
                    j_reg <= 3'd0;
                end
                ST_CACC:
                begin
                    j_reg <= j_reg + 3'd1;
                end
                ST_NCHK:
                begin
                    k_reg <= 2'd0;
                    c_reg <= 2'd0;
                end
                ST_SQACC:
                begin
                    c_reg   <= (c_reg == 2'd2) ? 2'd0 : c_reg + 2'd1;
                    cnt_reg <= 5'd0;
                end
                ST_ROOT:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                end
                ST_DINIT:
                begin
                    cnt_reg <= 5'd0;
                end
                ST_DSTEP:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == DIV_LAST)
                    begin
                        // back to component 0 so the emit step indexes vertex rows only
                        c_reg <= (c_reg == 2'd2) ? 2'd0 : c_reg + 2'd1;
                        k_reg <= 2'd0;
                    end
                end
                ST_EMIT:
                begin
                    if (load_out)
                    begin
                        k_reg <= k_reg + 2'd1;
                    end
                end
                default:
                begin
                    cnt_reg <= cnt_reg;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        case (state_reg)
            ST_IDLE:
            begin
                acc_reg <= '0;
                for (int i = 0; i < VTX_COORDS; i++)
                begin
                    vtx_reg[i] <= head.item.vtx[i];
                end
            end
            ST_XACC:   acc_reg <= acc_add;
            ST_XFIN:
            begin
                pos_reg[4'({k_reg, 1'b0}) + 4'(k_reg) + 4'(r_reg)] <= xf_sat;
                acc_reg <= '0;
            end
            ST_EDGE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    e1_reg[i] <= fit1[i];
                    e2_reg[i] <= fit2[i];
                end
                acc_reg <= '0;
            end
            ST_CACC:
            begin
                if (j_reg[0])
                begin
                    neg_reg[cx_comp] <= acc_sub[65];
                    mag_reg[cx_comp] <= acc_sub[65] ? 62'(-acc_sub) : acc_sub[61:0];
                    acc_reg          <= '0;
                end
                else
                begin
                    acc_reg <= acc_add;
                end
            end
            ST_NCHK:
            begin
                degen_reg <= (mag_or == '0);
                for (int i = 0; i < 3; i++)
                begin
                    norm_reg[i] <= '0;
                end
            end
            ST_NSHIFT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (mag_or[61:31] != '0)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                    else if (!mag_or[30])
                    begin
                        mag_reg[i] <= mag_reg[i] << 1;
                    end
                end
                acc_reg <= '0;
            end
            ST_SQACC:
            begin
                acc_reg  <= acc_add;
                rx_reg   <= acc_add[63:0];
                rres_reg <= '0;
                rbit_reg <= 64'd1 << 62;
            end
            ST_ROOT:
            begin
                rx_reg   <= rx_step;
                rres_reg <= rres_step;
                rbit_reg <= rbit_reg >> 2;
                len_reg  <= rres_step[32:0];
            end
            ST_DINIT:
            begin
                rem_reg <= 33'(div_num[45:16]);
                qsh_reg <= div_num[15:0];
            end
            ST_DSTEP:
            begin
                rem_reg <= div_ge ? 33'(rem2 - {1'b0, len_reg}) : rem2[32:0];
                qsh_reg <= quot;
                if (cnt_reg == DIV_LAST)
                begin
                    norm_reg[c_reg] <= neg_reg[c_reg] ? -$signed(quot) : $signed(quot);
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase

        if (load_out)
        begin
            opos_x_reg  <= pos_reg[vidx];
            opos_y_reg  <= pos_reg[vidx + 4'd1];
            opos_z_reg  <= pos_reg[vidx + 4'd2];
            onorm_x_reg <= norm_reg[0];
            onorm_y_reg <= norm_reg[1];
            onorm_z_reg <= norm_reg[2];
            odegen_reg  <= degen_reg;
            olast_reg   <= (k_reg == 2'd2);
        end
    end

    assign result_valid = out_valid_reg;
    assign pos_x        = opos_x_reg;
    assign pos_y        = opos_y_reg;
    assign pos_z        = opos_z_reg;
    assign norm_x       = onorm_x_reg;
    assign norm_y       = onorm_y_reg;
    assign norm_z       = onorm_z_reg;
    assign degenerate   = odegen_reg;
    assign last_vertex  = olast_reg;

endmodule

/* rtl/triangle_transform_face_normal.sv */
// channel   direction  handshake                  payload
// item      in         item_valid / item_stall    command, entry_index, entry_value, a_* .. c_*
// result    out        result_valid / result_stall pos_*, norm_*, degenerate, last_vertex
//
// a load word is stored by the back end straight from idle; a triangle works through
// the one shared 32x32 multiplier (27 transform, 6 cross, 3 square products),
// the 32-step square root and three 16-step divisions, plus up to 31 normalize shifts
// reset leaves the model matrix at identity with zero translation and the queue empty
// the two-word queue takes words until it is full while the back end works or the result stalls
// a stalled result word holds in the output register while the back end waits
module triangle_transform_face_normal import ttfn_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        command,
    input  logic [3:0]  entry_index,
    input  coord_t      entry_value,
    input  coord_t      a_x,
    input  coord_t      a_y,
    input  coord_t      a_z,
    input  coord_t      b_x,
    input  coord_t      b_y,
    input  coord_t      b_z,
    input  coord_t      c_x,
    input  coord_t      c_y,
    input  coord_t      c_z,
    output logic        result_valid,
    input  logic        result_stall,
    output coord_t      pos_x,
    output coord_t      pos_y,
    output coord_t      pos_z,
    output norm_t       norm_x,
    output norm_t       norm_y,
    output norm_t       norm_z,
    output logic        degenerate,
    output logic        last_vertex
);

    item_t       in_item;
    queue_head_t head;
    logic        head_pop;

    // command 0 is a matrix load
    always_comb
    begin
        in_item.is_load = ~command;
        in_item.idx     = entry_index;
        in_item.value   = entry_value;
        in_item.vtx[0]  = a_x;
        in_item.vtx[1]  = a_y;
        in_item.vtx[2]  = a_z;
        in_item.vtx[3]  = b_x;
        in_item.vtx[4]  = b_y;
        in_item.vtx[5]  = b_z;
        in_item.vtx[6]  = c_x;
        in_item.vtx[7]  = c_y;
        in_item.vtx[8]  = c_z;
    end

    // front: accept, drop out-of-range loads, queue in order
    ttfn_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .in_item    (in_item),
        .head       (head),
        .head_pop   (head_pop)
    );

    // back: matrix store, transform, face normal, three result words
    ttfn_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_pop     (head_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .norm_x       (norm_x),
        .norm_y       (norm_y),
        .norm_z       (norm_z),
        .degenerate   (degenerate),
        .last_vertex  (last_vertex)
    );

endmodule

/* rtl/ttfn_checker.sv */
module ttfn_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               result_valid,
    input logic               result_stall,
    input logic signed [31:0] pos_x,
    input logic signed [15:0] norm_x,
    input logic signed [15:0] norm_y,
    input logic signed [15:0] norm_z,
    input logic               degenerate,
    input logic               last_vertex
);

    // stalled word stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result word dropped under stall");

    // stalled word holds (pos_x and last_vertex are checked)
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(pos_x) && $stable(last_vertex))
        else $error("result word changed under stall");

    // flat face gives a zero normal
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && degenerate |-> norm_x == 16'sd0 && norm_y == 16'sd0
            && norm_z == 16'sd0)
        else $error("degenerate word with nonzero normal");

    // unit normal stays within one
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !degenerate |-> norm_x <= 16'sd16384 && norm_x >= -16'sd16384
            && norm_y <= 16'sd16384 && norm_y >= -16'sd16384
            && norm_z <= 16'sd16384 && norm_z >= -16'sd16384)
        else $error("normal component out of range");

endmodule

bind triangle_transform_face_normal ttfn_checker u_ttfn_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .pos_x        (pos_x),
    .norm_x       (norm_x),
    .norm_y       (norm_y),
    .norm_z       (norm_z),
    .degenerate   (degenerate),
    .last_vertex  (last_vertex)
);
